>>> src/three_cpu_mailbox_port_decoder_core_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the three-processor mailbox port decoder.
// Each macro expands to one labeled concurrent assertion that is disabled
// while reset is high.
// ---------------------------------------------------------------------------
`ifndef THREE_CPU_MAILBOX_PORT_DECODER_CORE_ASSERT_SVH
`define THREE_CPU_MAILBOX_PORT_DECODER_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TCMPD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TCMPD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> src/tcmpd_pkg.sv
// ---------------------------------------------------------------------------
// tcmpd_pkg
// Types and codes shared by the mailbox port decoder: transaction payloads,
// processor and access codes, port addresses and configuration indexes.
// ---------------------------------------------------------------------------
package tcmpd_pkg;

   // Issuing processor codes.
   localparam logic [1:0] CPU_MAIN   = 2'd0;
   localparam logic [1:0] CPU_SPRITE = 2'd1;
   localparam logic [1:0] CPU_ROTATE = 2'd2;

   // Access direction codes.
   localparam logic REQ_READ  = 1'b0;
   localparam logic REQ_WRITE = 1'b1;

   // Main processor ports.
   localparam logic [7:0] PORT_SOUND_LAST  = 8'h05;
   localparam logic [7:0] PORT_ROTATE_BOX  = 8'h10;
   localparam logic [7:0] PORT_SPRITE_BOX  = 8'h20;
   localparam logic [7:0] PORT_PLAYER1     = 8'h30;
   localparam logic [7:0] PORT_PLAYER2     = 8'h31;
   localparam logic [7:0] PORT_DIP_A       = 8'h32;
   localparam logic [7:0] PORT_DIP_B       = 8'h33;
   localparam logic [7:0] PORT_DIP_SPARE0  = 8'h34;
   localparam logic [7:0] PORT_DIP_SPARE1  = 8'h35;
   localparam logic [7:0] PORT_SYSTEM      = 8'h36;
   localparam logic [7:0] PORT_STATUS      = 8'h37;

   // Sub processor ports.
   localparam logic [7:0] PORT_SPRITE_MBOX = 8'h80;
   localparam logic [7:0] PORT_ROTATE_MBOX = 8'h40;
   localparam logic [7:0] PORT_BANK        = 8'h00;
   localparam logic [7:0] PORT_WRAP1       = 8'h10;
   localparam logic [7:0] PORT_ENABLE0     = 8'h12;
   localparam logic [7:0] PORT_ENABLE1     = 8'h13;
   localparam logic [7:0] PORT_WRAP0       = 8'h14;
   localparam logic [7:0] PORT_PALETTE     = 8'h50;

   localparam logic [7:0] BYTE_ALL_ONES    = 8'hff;

   // Configuration register indexes.
   localparam int unsigned CSR_INDEX_W = 1;
   localparam logic [CSR_INDEX_W-1:0] CSR_DIP_A = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DIP_B = 1'b1;

   // Input transaction.
   typedef struct packed {
      logic [1:0] cpu_sel;
      logic       req_type;
      logic [7:0] port_addr;
      logic [7:0] wdata;
      logic [7:0] player1_bits;
      logic [7:0] player2_bits;
      logic [7:0] system_bits;
   } req_payload_type;

   // Result transaction.
   typedef struct packed {
      logic [7:0] rdata;
      logic       main_irq;
      logic       sprite_irq;
      logic       rotate_irq;
      logic [3:0] rom_bank;
      logic [1:0] layer_enable;
      logic [1:0] wrap_enable;
      logic [7:0] palette_bank;
      logic       sound_strobe;
      logic [2:0] sound_chip;
   } rsp_payload_type;

endpackage

>>> src/three_cpu_mailbox_port_decoder_core.sv
// ---------------------------------------------------------------------------
// three_cpu_mailbox_port_decoder_core
// The result of an accepted transaction is registered and valid in the next cycle.
// Throughput: one transaction per cycle while results are taken, set by the single result register.
// Reset clears all mailboxes, flags and latched bytes; DIP banks reset to 0xff.
// ---------------------------------------------------------------------------
`include "three_cpu_mailbox_port_decoder_core_assert.svh"

module three_cpu_mailbox_port_decoder_core
   import tcmpd_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  req_payload_type        req_payload,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output rsp_payload_type        rsp_payload,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [7:0]             csr_wdata
);

   // State registers and their next values.
   logic [7:0]      dip_a_ff, dip_b_ff;
   logic [7:0]      to_sprite_box_ff, to_sprite_box_in;
   logic [7:0]      to_rotate_box_ff, to_rotate_box_in;
   logic [7:0]      from_sprite_box_ff, from_sprite_box_in;
   logic [7:0]      from_rotate_box_ff, from_rotate_box_in;
   logic [1:0]      reply_pending_ff, reply_pending_in;
   logic [1:0]      sub_irq_lines_ff, sub_irq_lines_in;
   logic [7:0]      bank_byte_ff, bank_byte_in;
   logic [3:0]      layer_wrap_bits_ff, layer_wrap_bits_in;
   logic [7:0]      palette_byte_ff, palette_byte_in;
   logic            rsp_valid_ff;
   rsp_payload_type rsp_payload_ff, rsp_payload_in;
   logic            req_fire;
   logic            inv_bit;
   logic            is_wr;
   logic [7:0]      port;
   logic [7:0]      rd;
   logic            strobe;
   logic [2:0]      chip;

   // The result register frees up whenever its transaction is taken.
   assign req_ready   = !rsp_valid_ff || rsp_ready;
   assign req_fire    = req_valid && req_ready;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   assign is_wr   = (req_payload.req_type == REQ_WRITE);
   assign port    = req_payload.port_addr;
   assign inv_bit = ~req_payload.wdata[0];

   // Decode one access and compute the state after it.
   always_comb begin
      to_sprite_box_in   = to_sprite_box_ff;
      to_rotate_box_in   = to_rotate_box_ff;
      from_sprite_box_in = from_sprite_box_ff;
      from_rotate_box_in = from_rotate_box_ff;
      reply_pending_in   = reply_pending_ff;
      sub_irq_lines_in   = sub_irq_lines_ff;
      bank_byte_in       = bank_byte_ff;
      layer_wrap_bits_in = layer_wrap_bits_ff;
      palette_byte_in    = palette_byte_ff;
      rd                 = 8'h00;
      strobe             = 1'b0;
      chip               = 3'd0;

      case (req_payload.cpu_sel)
         CPU_MAIN: begin
            if (is_wr) begin
               if (port <= PORT_SOUND_LAST) begin
                  strobe = 1'b1;
                  chip   = port[2:0];
               end else if (port == PORT_ROTATE_BOX) begin
                  to_rotate_box_in    = req_payload.wdata;
                  sub_irq_lines_in[1] = 1'b1;
               end else if (port == PORT_SPRITE_BOX) begin
                  to_sprite_box_in    = req_payload.wdata;
                  sub_irq_lines_in[0] = 1'b1;
               end
            end else begin
               case (port)
                  PORT_ROTATE_BOX: begin
                     reply_pending_in[0] = 1'b0;
                     rd                  = from_rotate_box_ff;
                  end
                  PORT_SPRITE_BOX: begin
                     reply_pending_in[1] = 1'b0;
                     rd                  = from_sprite_box_ff;
                  end
                  PORT_PLAYER1:    rd = req_payload.player1_bits;
                  PORT_PLAYER2:    rd = req_payload.player2_bits;
                  PORT_DIP_A:      rd = dip_a_ff;
                  PORT_DIP_B:      rd = dip_b_ff;
                  PORT_DIP_SPARE0: rd = BYTE_ALL_ONES;
                  PORT_DIP_SPARE1: rd = BYTE_ALL_ONES;
                  PORT_SYSTEM:     rd = req_payload.system_bits;
                  PORT_STATUS:     rd = {6'd0, reply_pending_ff};
                  default:         rd = 8'h00;
               endcase
            end
         end
         CPU_SPRITE: begin
            if (port == PORT_SPRITE_MBOX) begin
               if (is_wr) begin
                  from_sprite_box_in  = req_payload.wdata;
                  reply_pending_in[1] = 1'b1;
               end else begin
                  sub_irq_lines_in[0] = 1'b0;
                  rd                  = to_sprite_box_ff;
               end
            end
         end
         CPU_ROTATE: begin
            // Writes decode the bank, wrap, enable, mailbox and palette ports; reads only the mailbox.
            if (is_wr) begin
               case (port)
                  PORT_BANK:     bank_byte_in          = req_payload.wdata;
                  PORT_WRAP1:    layer_wrap_bits_in[3] = inv_bit;
                  PORT_WRAP0:    layer_wrap_bits_in[2] = inv_bit;
                  PORT_ENABLE0:  layer_wrap_bits_in[0] = inv_bit;
                  PORT_ENABLE1:  layer_wrap_bits_in[1] = inv_bit;
                  PORT_ROTATE_MBOX: begin
                     from_rotate_box_in  = req_payload.wdata;
                     reply_pending_in[0] = 1'b1;
                  end
                  PORT_PALETTE:  palette_byte_in       = req_payload.wdata;
                  default: ;
               endcase
            end else if (port == PORT_ROTATE_MBOX) begin
               sub_irq_lines_in[1] = 1'b0;
               rd                  = to_rotate_box_ff;
            end
         end
         default: ;
      endcase

      // Result fields reflect the state after the access.
      rsp_payload_in.rdata        = rd;
      rsp_payload_in.main_irq     = |reply_pending_in;
      rsp_payload_in.sprite_irq   = sub_irq_lines_in[0];
      rsp_payload_in.rotate_irq   = sub_irq_lines_in[1];
      rsp_payload_in.rom_bank     = {bank_byte_in[4], bank_byte_in[5],
                                     bank_byte_in[6], bank_byte_in[7]};
      rsp_payload_in.layer_enable = layer_wrap_bits_in[1:0];
      rsp_payload_in.wrap_enable  = layer_wrap_bits_in[3:2];
      rsp_payload_in.palette_bank = palette_byte_in;
      rsp_payload_in.sound_strobe = strobe;
      rsp_payload_in.sound_chip   = chip;
   end

   // Mailbox and control state, updated on each accepted transaction.
   always_ff @(posedge clock) begin
      if (reset) begin
         to_sprite_box_ff   <= 8'h00;
         to_rotate_box_ff   <= 8'h00;
         from_sprite_box_ff <= 8'h00;
         from_rotate_box_ff <= 8'h00;
         reply_pending_ff   <= 2'b00;
         sub_irq_lines_ff   <= 2'b00;
         bank_byte_ff       <= 8'h00;
         layer_wrap_bits_ff <= 4'h0;
         palette_byte_ff    <= 8'h00;
      end else if (req_fire) begin
         to_sprite_box_ff   <= to_sprite_box_in;
         to_rotate_box_ff   <= to_rotate_box_in;
         from_sprite_box_ff <= from_sprite_box_in;
         from_rotate_box_ff <= from_rotate_box_in;
         reply_pending_ff   <= reply_pending_in;
         sub_irq_lines_ff   <= sub_irq_lines_in;
         bank_byte_ff       <= bank_byte_in;
         layer_wrap_bits_ff <= layer_wrap_bits_in;
         palette_byte_ff    <= palette_byte_in;
      end
   end

   // DIP switch configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         dip_a_ff <= BYTE_ALL_ONES;
         dip_b_ff <= BYTE_ALL_ONES;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_DIP_A: dip_a_ff <= csr_wdata;
            CSR_DIP_B: dip_b_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Result register: loads on accept, empties when the transaction is taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_payload_ff <= rsp_payload_in;
      end
   end

   // A sprite reply write must leave the main interrupt raised.
   `TCMPD_ASSERT_NEXT(a_sprite_reply_irq, clock, reset,
      req_fire && req_payload.cpu_sel == CPU_SPRITE && is_wr && port == PORT_SPRITE_MBOX,
      rsp_valid && rsp_payload.main_irq, "sprite reply did not raise main interrupt")

   // A main write to the sprite mailbox must raise the sprite interrupt.
   `TCMPD_ASSERT_NEXT(a_sprite_mail_irq, clock, reset,
      req_fire && req_payload.cpu_sel == CPU_MAIN && is_wr && port == PORT_SPRITE_BOX,
      rsp_valid && rsp_payload.sprite_irq, "sprite mailbox write did not raise irq")

   // Write transactions always return zero read data.
   `TCMPD_ASSERT_NEXT(a_write_rdata_zero, clock, reset,
      req_fire && is_wr,
      rsp_payload.rdata == 8'h00, "write transaction returned nonzero read data")

   // A stalled result must block new transactions.
   `TCMPD_ASSERT_NOW(a_stall_blocks, clock, reset,
      rsp_valid && !rsp_ready,
      !req_fire, "transaction accepted over a stalled result")

endmodule
